[hdl/cef_pkg.sv]
// ----------------------------------------------------------------------------
// cef_pkg
// Shared types and codes for the coalescing event fifo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cef_pkg;

    localparam int DEPTH_DEFAULT        = 16;
    localparam int PAYLOAD_BITS_DEFAULT = 64;

    localparam int EVENT_TYPE_W    = 8;
    localparam int EVENT_PAYLOAD_W = 64;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;
    localparam int ENABLE_W        = 2;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POLL = 1'b1;

    // push status codes
    localparam logic [STATUS_W-1:0] ST_POLL   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_APPEND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COAL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DROP   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd2;

    typedef struct packed {
        logic                       func;
        logic [EVENT_TYPE_W-1:0]    event_type;
        logic [EVENT_PAYLOAD_W-1:0] event_payload;
    } req_t;

    typedef struct packed {
        logic                       out_valid;
        logic [EVENT_TYPE_W-1:0]    out_type;
        logic [EVENT_PAYLOAD_W-1:0] out_payload;
        logic [STATUS_W-1:0]        push_status;
        logic [OCC_W-1:0]           occupancy;
    } rsp_t;

endpackage

[hdl/cef_ram.sv]
// ----------------------------------------------------------------------------
// cef_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cef_ram #(
    parameter int DEPTH = cef_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = cef_pkg::EVENT_TYPE_W
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/coalescing_event_fifo.sv]
// ----------------------------------------------------------------------------
// coalescing_event_fifo
// Ring-buffer event queue. A push of an enabled coalescible type first searches
// the queued entries from newest to oldest and overwrites the payload of the
// first entry of the same type; otherwise it appends, or is dropped when the
// queue is full. A poll returns the oldest entry. One item is handled at a time,
// and a coalescible push searches up to the whole occupancy, since the search
// reads the type memory through its single read port one entry per cycle. The
// result sits in an output register, so the next item is accepted while it
// waits; a result is moved out only when that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coalescing_event_fifo #(
    parameter int DEPTH        = cef_pkg::DEPTH_DEFAULT,
    parameter int PAYLOAD_BITS = cef_pkg::PAYLOAD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  cef_pkg::req_t                      req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output cef_pkg::rsp_t                      rsp,
    input  logic                               cfg_we,
    input  logic [cef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cef_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(DEPTH);
    localparam int PTR_W = $clog2(2 * DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(DEPTH);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POLL_DATA,
        S_SCAN,
        S_PUSH_END,
        S_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [cef_pkg::EVENT_TYPE_W-1:0]    type_reg, type_next;
    logic [PAYLOAD_BITS-1:0]             payload_reg, payload_next;
    logic [PTR_W-1:0]                    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]                    scan_ptr_reg, scan_ptr_next;
    logic [LVL_W-1:0]                    scan_left_reg, scan_left_next;
    logic                                cmp_valid_reg, cmp_valid_next;
    logic                                cmp_last_reg, cmp_last_next;
    logic [AW-1:0]                       cmp_slot_reg, cmp_slot_next;
    logic                                res_valid_reg, res_valid_next;
    logic [cef_pkg::EVENT_TYPE_W-1:0]    res_type_reg, res_type_next;
    logic [PAYLOAD_BITS-1:0]             res_payload_reg, res_payload_next;
    logic [cef_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    cef_pkg::rsp_t                       rsp_reg, rsp_next;
    logic [cef_pkg::EVENT_TYPE_W-1:0]    type_a_reg, type_a_next;
    logic [cef_pkg::EVENT_TYPE_W-1:0]    type_b_reg, type_b_next;
    logic [cef_pkg::ENABLE_W-1:0]        enable_reg, enable_next;

    logic                                ram_type_we;
    logic                                ram_pl_we;
    logic [AW-1:0]                       ram_waddr;
    logic [AW-1:0]                       ram_raddr;
    logic [cef_pkg::EVENT_TYPE_W-1:0]    type_rdata;
    logic [PAYLOAD_BITS-1:0]             pl_rdata;

    logic [LVL_W-1:0]                    level;
    logic [PTR_W-1:0]                    scan_prev;
    logic                                coalescible;

    function automatic logic [AW-1:0] slot_of(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] s;
        s = (p >= PTR_HALF) ? (p - PTR_HALF) : p;
        return s[AW-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : (p + PTR_W'(1));
    endfunction

    cef_ram #(
        .DEPTH (DEPTH),
        .WIDTH (cef_pkg::EVENT_TYPE_W)
    ) u_type_ram (
        .clk   (clk),
        .we    (ram_type_we),
        .waddr (ram_waddr),
        .wdata (type_reg),
        .raddr (ram_raddr),
        .rdata (type_rdata)
    );

    cef_ram #(
        .DEPTH (DEPTH),
        .WIDTH (PAYLOAD_BITS)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_pl_we),
        .waddr (ram_waddr),
        .wdata (payload_reg),
        .raddr (ram_raddr),
        .rdata (pl_rdata)
    );

    // fill level from pointers that count modulo twice the depth
    always_comb
    begin
        logic [PTR_W:0] diff;
        diff = (wr_ptr_reg >= rd_ptr_reg)
             ? ({1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg})
             : ({1'b0, wr_ptr_reg} + (PTR_W+1)'(2 * DEPTH) - {1'b0, rd_ptr_reg});
        level = diff[LVL_W-1:0];
    end

    assign scan_prev   = (scan_ptr_reg == '0) ? PTR_LAST : (scan_ptr_reg - PTR_W'(1));
    assign coalescible = (enable_reg[0] && (req.event_type == type_a_reg))
                      || (enable_reg[1] && (req.event_type == type_b_reg));

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next       = state_reg;
        type_next        = type_reg;
        payload_next     = payload_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        scan_ptr_next    = scan_ptr_reg;
        scan_left_next   = scan_left_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_last_next    = cmp_last_reg;
        cmp_slot_next    = cmp_slot_reg;
        res_valid_next   = res_valid_reg;
        res_type_next    = res_type_reg;
        res_payload_next = res_payload_reg;
        res_status_next  = res_status_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_next         = rsp_reg;
        type_a_next      = type_a_reg;
        type_b_next      = type_b_reg;
        enable_next      = enable_reg;
        ram_type_we      = 1'b0;
        ram_pl_we        = 1'b0;
        ram_waddr        = slot_of(wr_ptr_reg);
        ram_raddr        = slot_of(rd_ptr_reg);

        if (cfg_we)
        begin
            unique case (cfg_index)
                cef_pkg::REG_TYPE_A: type_a_next = cfg_data;
                cef_pkg::REG_TYPE_B: type_b_next = cfg_data;
                cef_pkg::REG_ENABLE: enable_next = cfg_data[cef_pkg::ENABLE_W-1:0];
                default: ;
            endcase
        end

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    type_next        = req.event_type;
                    payload_next     = req.event_payload[PAYLOAD_BITS-1:0];
                    cmp_valid_next   = 1'b0;
                    res_valid_next   = 1'b0;
                    res_type_next    = '0;
                    res_payload_next = '0;
                    res_status_next  = cef_pkg::ST_POLL;
                    if (req.func == cef_pkg::FUNC_POLL)
                    begin
                        // read address already points at the oldest entry
                        state_next = (level == '0) ? S_DONE : S_POLL_DATA;
                    end
                    else if (coalescible && (level != '0))
                    begin
                        scan_ptr_next  = wr_ptr_reg;
                        scan_left_next = level;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_PUSH_END;
                    end
                end
            end

            S_POLL_DATA:
            begin
                res_valid_next   = 1'b1;
                res_type_next    = type_rdata;
                res_payload_next = pl_rdata;
                rd_ptr_next      = ptr_inc(rd_ptr_reg);
                state_next       = S_DONE;
            end

            S_SCAN:
            begin
                // one read issued and one compare done per cycle, newest first
                if (cmp_valid_reg && (type_rdata == type_reg))
                begin
                    ram_pl_we       = 1'b1;
                    ram_waddr       = cmp_slot_reg;
                    cmp_valid_next  = 1'b0;
                    res_status_next = cef_pkg::ST_COAL;
                    state_next      = S_DONE;
                end
                else if (cmp_valid_reg && cmp_last_reg)
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_PUSH_END;
                end
                else if (scan_left_reg != '0)
                begin
                    ram_raddr      = slot_of(scan_prev);
                    scan_ptr_next  = scan_prev;
                    scan_left_next = scan_left_reg - LVL_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = slot_of(scan_prev);
                    cmp_last_next  = (scan_left_reg == LVL_W'(1));
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_PUSH_END;
                end
            end

            S_PUSH_END:
            begin
                if (level == LVL_FULL)
                begin
                    res_status_next = cef_pkg::ST_DROP;
                end
                else
                begin
                    ram_type_we     = 1'b1;
                    ram_pl_we       = 1'b1;
                    wr_ptr_next     = ptr_inc(wr_ptr_reg);
                    res_status_next = cef_pkg::ST_APPEND;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.out_valid    = res_valid_reg;
                    rsp_next.out_type     = res_type_reg;
                    rsp_next.out_payload  = cef_pkg::EVENT_PAYLOAD_W'(res_payload_reg);
                    rsp_next.push_status  = res_status_reg;
                    rsp_next.occupancy    = cef_pkg::OCC_W'(level);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            type_reg        <= '0;
            payload_reg     <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            scan_ptr_reg    <= '0;
            scan_left_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_last_reg    <= 1'b0;
            cmp_slot_reg    <= '0;
            res_valid_reg   <= 1'b0;
            res_type_reg    <= '0;
            res_payload_reg <= '0;
            res_status_reg  <= cef_pkg::ST_POLL;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            type_a_reg      <= '0;
            type_b_reg      <= '0;
            enable_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            type_reg        <= type_next;
            payload_reg     <= payload_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            scan_ptr_reg    <= scan_ptr_next;
            scan_left_reg   <= scan_left_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_last_reg    <= cmp_last_next;
            cmp_slot_reg    <= cmp_slot_next;
            res_valid_reg   <= res_valid_next;
            res_type_reg    <= res_type_next;
            res_payload_reg <= res_payload_next;
            res_status_reg  <= res_status_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
            type_a_reg      <= type_a_next;
            type_b_reg      <= type_b_next;
            enable_reg      <= enable_next;
        end
    end

endmodule

[hdl/cef_checker.sv]
// ----------------------------------------------------------------------------
// cef_checker
// Port-level checks for the coalescing event fifo, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cef_checker #(
    parameter int DEPTH = cef_pkg::DEPTH_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cef_pkg::rsp_t rsp
);

    localparam logic [cef_pkg::OCC_W-1:0] OCC_FULL = cef_pkg::OCC_W'(DEPTH);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // the fifo is not ready right after it accepts an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after an accepted item");

    // only a poll returns an event
    a_valid_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.out_valid |-> rsp.push_status == cef_pkg::ST_POLL)
        else $error("event returned for a push");

    // a drop only happens with the queue full
    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.push_status == cef_pkg::ST_DROP) |-> rsp.occupancy == OCC_FULL)
        else $error("push dropped with room left");

endmodule

bind coalescing_event_fifo cef_checker #(.DEPTH(DEPTH)) u_cef_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
